// ----- hdl/lzssbd_pkg.sv -----
// Shared constants, types and parser state for the LZSS bit-packed stream decoder.
`timescale 1ns / 1ps

package lzssbd_pkg;

  localparam int WINDOW_BITS = 10;
  localparam int LENGTH_BITS = 4;

  localparam int WIN_DEPTH = 1 << WINDOW_BITS;
  // widest field gathered in the accumulator: literal or window position
  localparam int ACC_W     = (WINDOW_BITS > 8) ? WINDOW_BITS : 8;
  localparam int CNT_W     = $clog2(ACC_W + 1);
  // copy length count+2 never reaches 2**(LENGTH_BITS+1)
  localparam int LEN_W     = LENGTH_BITS + 1;
  localparam int FILL_W    = WINDOW_BITS + 1;

  localparam logic [WINDOW_BITS-1:0] WP_RESET =
    WINDOW_BITS'(WIN_DEPTH - (1 << LENGTH_BITS) - 1);
  localparam logic [7:0] FILL_BYTE = 8'h20;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_LIT,
    PH_POS,
    PH_CNT
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_LIT,
    EV_MATCH
  } event_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIT,
    ST_RD,
    ST_WR
  } state_e;

  typedef struct packed {
    phase_e                  phase;
    logic [ACC_W-1:0]        acc;
    logic [CNT_W-1:0]        cnt;
    logic [WINDOW_BITS-1:0]  mpos;
  } parse_t;

  localparam parse_t PARSE_RST = '{phase: PH_FLAG, acc: '0, cnt: '0, mpos: '0};

endpackage

// ----- hdl/lzssbd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module lzssbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/lzss_bitstream_decoder_top.sv -----
// LZSS bit-packed stream decoder: bit parser, window copy sequencer and output register.
//
// Usage:
//   Slave channel s_axis takes one compressed byte per transfer (tdata), read MSB
//   first; tlast marks the final byte of a stream, after which any partial token
//   is dropped. Master channel m_axis gives one decoded byte per transfer, with
//   tlast on the last byte caused by a given input byte.
//   All eight bits of an input byte are parsed in the cycle it is accepted; at
//   most one token completes per byte.
//   A literal passes through ST_LIT, and a match passes through ST_RD and ST_WR for
//   each copied byte: a window read, then a write/emit. The registered read data
//   of the window RAM sets this order, and the next byte is taken only once the
//   copy is done.
//   First output is loaded into the output register from ST_LIT for a literal,
//   and from ST_WR, after the ST_RD read, for a match.
//   Reset: window reads as spaces until written (a fill count tracks written
//   entries, no clearing pass), write pointer starts at window size minus 17.
//   Stall: a result waits in the output register; the copy sequencer holds until
//   m_axis_tready frees it, and no input is taken meanwhile during a copy.
`timescale 1ns / 1ps

module lzss_bitstream_decoder_top
  import lzssbd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // stream_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // run_last
);

  state_e                 state_q, state_d;
  parse_t                 parse_q, parse_d;
  event_e                 ev_kind;
  logic [7:0]             ev_lit;
  logic [WINDOW_BITS-1:0] ev_pos;
  logic [LEN_W-1:0]       ev_len;

  logic [7:0]             lit_q;
  logic [WINDOW_BITS-1:0] pos_q;
  logic [LEN_W-1:0]       rem_q;
  logic [WINDOW_BITS-1:0] wp_q;
  logic [FILL_W-1:0]      fill_q;

  logic                   out_valid_q;
  logic [7:0]             out_data_q;
  logic                   out_last_q;

  logic                   in_acc;
  logic                   out_free;
  logic                   out_load;
  logic                   out_last_d;
  logic [7:0]             wr_byte;
  logic                   ram_we;
  logic                   ram_re;
  logic [7:0]             ram_rdata;
  logic [WINDOW_BITS-1:0] rd_offset;
  logic                   rd_written;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Parse all eight bits of the byte; only one token can finish inside it.
  always_comb begin
    logic bit_v;
    parse_d = parse_q;
    ev_kind = EV_NONE;
    ev_lit  = '0;
    ev_pos  = '0;
    ev_len  = '0;
    for (int b = 7; b >= 0; b--) begin
      bit_v = s_axis_tdata[b];
      if (parse_d.phase == PH_FLAG) begin
        parse_d.phase = bit_v ? PH_LIT : PH_POS;
        parse_d.acc   = '0;
        parse_d.cnt   = '0;
      end else begin
        parse_d.acc = {parse_d.acc[ACC_W-2:0], bit_v};
        parse_d.cnt = parse_d.cnt + CNT_W'(1);
        unique case (parse_d.phase)
          PH_LIT: begin
            if (parse_d.cnt >= CNT_W'(8)) begin
              ev_kind = EV_LIT;
              ev_lit  = parse_d.acc[7:0];
              parse_d = PARSE_RST;
            end
          end
          PH_POS: begin
            if (parse_d.cnt >= CNT_W'(WINDOW_BITS)) begin
              parse_d.mpos  = parse_d.acc[WINDOW_BITS-1:0];
              parse_d.acc   = '0;
              parse_d.cnt   = '0;
              parse_d.phase = PH_CNT;
            end
          end
          PH_CNT: begin
            if (parse_d.cnt >= CNT_W'(LENGTH_BITS)) begin
              ev_kind = EV_MATCH;
              ev_pos  = parse_d.mpos;
              ev_len  = LEN_W'(parse_d.acc[LENGTH_BITS-1:0]) + LEN_W'(2);
              parse_d = PARSE_RST;
            end
          end
          default: ;
        endcase
      end
    end
    if (s_axis_tlast) begin
      parse_d = PARSE_RST;
    end
  end

  // Entries are written in order from WP_RESET; fill_q counts them up to the depth.
  assign rd_offset  = pos_q - WP_RESET;
  assign rd_written = {1'b0, rd_offset} < fill_q;

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    out_load      = 1'b0;
    out_last_d    = 1'b0;
    wr_byte       = lit_q;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_acc) begin
          unique case (ev_kind)
            EV_LIT:   state_d = ST_LIT;
            EV_MATCH: state_d = ST_RD;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_LIT: begin
        out_last_d = 1'b1;
        if (out_free) begin
          ram_we   = 1'b1;
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_RD: begin
        ram_re  = 1'b1;
        state_d = ST_WR;
      end
      ST_WR: begin
        wr_byte    = rd_written ? ram_rdata : FILL_BYTE;
        out_last_d = (rem_q == LEN_W'(1));
        if (out_free) begin
          ram_we   = 1'b1;
          out_load = 1'b1;
          state_d  = out_last_d ? ST_IDLE : ST_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      parse_q     <= PARSE_RST;
      rem_q       <= '0;
      wp_q        <= WP_RESET;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        parse_q <= parse_d;
        rem_q   <= ev_len;
      end else if (state_q == ST_WR && out_load) begin
        rem_q <= rem_q - LEN_W'(1);
      end
      if (ram_we) begin
        wp_q <= wp_q + WINDOW_BITS'(1);
        if (fill_q != FILL_W'(WIN_DEPTH)) begin
          fill_q <= fill_q + FILL_W'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lit_q <= ev_lit;
      pos_q <= ev_pos;
    end else if (state_q == ST_WR && out_load) begin
      pos_q <= pos_q + WINDOW_BITS'(1);
    end
    if (out_load) begin
      out_data_q <= wr_byte;
      out_last_q <= out_last_d;
    end
  end

  lzssbd_ram #(
    .WIDTH (8),
    .DEPTH (WIN_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (wr_byte),
    .re_i    (ram_re),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  a_we_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> out_load)
    else $error("window write without an emitted byte");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WIN_DEPTH))
    else $error("fill count beyond window depth");

  a_copy_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD || state_q == ST_WR) |-> rem_q != '0)
    else $error("copy in progress with no bytes left");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |=> state_q == ST_IDLE)
    else $error("sequencer did not return to idle after last byte");

  a_token_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ev_kind != EV_NONE) |=> !s_axis_tready)
    else $error("input taken while a token is still being emitted");

endmodule

// ----- tb/tb_lzss_bitstream_decoder_top.sv -----
// Testbench for the LZSS bit-packed stream decoder: directed and random bit streams.
`timescale 1ns / 1ps

module tb_lzss_bitstream_decoder_top;
  import lzssbd_pkg::*;

  typedef struct {
    logic [7:0] out_byte;
    logic       run_last;
  } decoded_t;

  // Decodes accepted bytes into expected output bytes and checks the output transfers.
  class lzss_scoreboard;
    logic [7:0]             win [WIN_DEPTH];
    logic [WINDOW_BITS-1:0] wp;
    logic [15:0]            acc;
    logic [4:0]             nbits;
    phase_e                 phase;
    logic [WINDOW_BITS-1:0] mpos;
    decoded_t               decoded_q[$];
    int                     errors;

    function new();
      foreach (win[i]) win[i] = FILL_BYTE;
      wp = WP_RESET;
      errors = 0;
      drop_token();
    endfunction

    function void drop_token();
      acc = '0;
      nbits = '0;
      phase = PH_FLAG;
      mpos = '0;
    endfunction

    function void emit(logic [7:0] v);
      decoded_t d;
      win[wp] = v;
      wp = wp + 1'b1;
      d.out_byte = v;
      d.run_last = 1'b0;
      decoded_q.push_back(d);
    endfunction

    function void note_input(logic [7:0] din, logic endf);
      logic                   b;
      logic [WINDOW_BITS-1:0] rd;
      int                     first;
      int                     len;
      first = decoded_q.size();
      for (int i = 7; i >= 0; i--) begin
        b = din[i];
        if (phase == PH_FLAG) begin
          phase = b ? PH_LIT : PH_POS;
          acc = '0;
          nbits = '0;
        end else begin
          acc = {acc[14:0], b};
          nbits = nbits + 1'b1;
          case (phase)
            PH_LIT: begin
              if (nbits >= 8) begin
                emit(acc[7:0]);
                drop_token();
              end
            end
            PH_POS: begin
              if (nbits >= WINDOW_BITS) begin
                mpos = acc[WINDOW_BITS-1:0];
                acc = '0;
                nbits = '0;
                phase = PH_CNT;
              end
            end
            default: begin
              if (nbits >= LENGTH_BITS) begin
                len = int'(acc[LENGTH_BITS-1:0]) + 2;
                rd = mpos;
                // read after each write so overlapping copies repeat fresh bytes
                repeat (len) begin
                  emit(win[rd]);
                  rd = rd + 1'b1;
                end
                drop_token();
              end
            end
          endcase
        end
      end
      if (endf) drop_token();
      if (decoded_q.size() > first) decoded_q[decoded_q.size()-1].run_last = 1'b1;
    endfunction

    function void check_output(logic [7:0] ob, logic rl);
      decoded_t exp_d;
      if (decoded_q.size() == 0) begin
        $error("unexpected output transfer: out_byte %h run_last %b", ob, rl);
        errors++;
        return;
      end
      exp_d = decoded_q.pop_front();
      if (ob !== exp_d.out_byte) begin
        $error("out_byte mismatch: expected %h, actual %h", exp_d.out_byte, ob);
        errors++;
      end
      if (rl !== exp_d.run_last) begin
        $error("run_last mismatch: expected %b, actual %b", exp_d.run_last, rl);
        errors++;
      end
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] data_byte
  logic       s_axis_tlast;   // stream_end
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] out_byte
  logic       m_axis_tlast;   // run_last

  lzss_scoreboard         sb;
  logic                   bitq[$];
  logic [WINDOW_BITS-1:0] gen_wp;
  logic                   no_idle;
  logic                   hold_req;
  int                     hold_cnt;

  lzss_bitstream_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function void push_field(int unsigned v, int w);
    for (int i = w - 1; i >= 0; i--) bitq.push_back(v[i]);
  endfunction

  function void push_literal(logic [7:0] v);
    push_field(1, 1);
    push_field(v, 8);
    gen_wp = gen_wp + 1'b1;
  endfunction

  function void push_match(logic [WINDOW_BITS-1:0] pos, int unsigned cnt);
    push_field(0, 1);
    push_field(pos, WINDOW_BITS);
    push_field(cnt, LENGTH_BITS);
    gen_wp = gen_wp + WINDOW_BITS'(cnt + 2);
  endfunction

  // Token tracking of gen_wp is approximate after dropped tokens; only steers positions.
  function void push_random_token();
    int unsigned            r;
    int unsigned            cnt;
    logic [WINDOW_BITS-1:0] pos;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      push_literal(8'($urandom));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50)      pos = gen_wp - WINDOW_BITS'($urandom_range(1, 48));
      else if (r < 80) pos = WINDOW_BITS'($urandom);
      else if (r < 90) pos = '0;
      else             pos = '1;
      r = $urandom_range(0, 99);
      if (r < 15)      cnt = (1 << LENGTH_BITS) - 1;
      else if (r < 25) cnt = 0;
      else             cnt = $urandom_range(0, (1 << LENGTH_BITS) - 1);
      push_match(pos, cnt);
    end
  endfunction

  function logic [7:0] pop_byte();
    logic [7:0] d;
    d = '0;
    repeat (8) d = {d[6:0], (bitq.size() > 0) ? bitq.pop_front() : 1'b0};
    return d;
  endfunction

  // Leaves tvalid high after the transfer; the caller or the next gap lowers it.
  task automatic send_byte(input logic [7:0] din, input logic last);
    if (!no_idle && $urandom_range(0, 99) < 18) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= din;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(din, last);
  endtask

  // Sends every queued bit, zero padded; the final byte ends the stream.
  task automatic flush_stream();
    while (bitq.size() > 8) send_byte(pop_byte(), 1'b0);
    send_byte(pop_byte(), 1'b1);
  endtask

  // Output side: random backpressure plus one long hold-off on request.
  initial begin
    hold_cnt = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata, m_axis_tlast);
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 400;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 18);
      end
    end
  end

  initial begin
    logic [7:0] din;
    logic       last;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    rst_ni        = 1'b0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    gen_wp        = WP_RESET;
    sb            = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes of literal, position and count; overlap and wrapped reads
    push_literal(8'h00);
    push_literal(8'hFF);
    push_match('0, 0);
    push_match('1, (1 << LENGTH_BITS) - 1);
    push_match(gen_wp - 1'b1, (1 << LENGTH_BITS) - 1);
    push_match(gen_wp - 2'd3, 5);
    push_match(WINDOW_BITS'(WIN_DEPTH - 4), (1 << LENGTH_BITS) - 1);
    flush_stream();
    // stream end inside a match token, then inside a literal token
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // tokens completed by the end byte itself
    push_literal(8'hA5);
    flush_stream();
    push_match(gen_wp - 2'd2, 0);
    flush_stream();

    for (int k = 0; k < 350; k++) begin
      no_idle = (k >= 120 && k < 200);
      if (k == 60) hold_req = 1'b1;
      if (k == 250) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (sb.pending() != 0) @(posedge clk_i);
      end
      last = ($urandom_range(0, 99) < 4);
      if ($urandom_range(0, 99) < 8) begin
        din = 8'($urandom);  // noise: shifts token alignment
      end else begin
        while (bitq.size() < 8) push_random_token();
        din = pop_byte();
      end
      if (last) bitq.delete();
      send_byte(din, last);
    end
    s_axis_tvalid <= 1'b0;
    no_idle = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/lzssbd_pkg.sv
hdl/lzssbd_ram.sv
hdl/lzss_bitstream_decoder_top.sv
tb/tb_lzss_bitstream_decoder_top.sv
